/* hw/rtl/sfvs_pkg.sv */
// shared constants, register codes and output saturation for the fade volume scaler
package sfvs_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int OUT_W     = 16;
    localparam int POS_W     = 32;
    localparam int VOL_W     = 31;
    localparam int LEN_W     = 32;
    localparam int GAIN_FRAC = 16;
    localparam int FADE_W    = GAIN_FRAC + 1;
    localparam int SQ_W      = 2 * GAIN_FRAC + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // product bit window: >>16, keep low 32, >>8
    localparam int PROD_LO   = GAIN_FRAC + 8;
    localparam int PROD_HI   = GAIN_FRAC + SAMPLE_W - 1;
    localparam int SAT_IN_W  = PROD_HI - PROD_LO + 1;

    localparam logic [FADE_W-1:0] FULL_GAIN = 17'h10000;
    localparam logic [OUT_W-1:0]  OUT_MAX   = 16'h7FFF;
    localparam logic [OUT_W-1:0]  OUT_MIN   = 16'h8000;

    localparam logic [VOL_W-1:0] MASTER_VOLUME_RST = 31'h0001_0000;
    localparam logic [LEN_W-1:0] FADE_LENGTH_RST   = 32'd176400;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH   = 1'b1;

    function automatic logic [OUT_W-1:0] sat16(input logic [SAT_IN_W-1:0] v);
        logic [OUT_W-1:0] r;
        if ((&v[SAT_IN_W-1:OUT_W-1]) || !(|v[SAT_IN_W-1:OUT_W-1]))
            r = v[OUT_W-1:0];
        else if (v[SAT_IN_W-1])
            r = OUT_MIN;
        else
            r = OUT_MAX;
        return r;
    endfunction

endpackage

/* hw/rtl/sfvs_div.sv */
// restoring divider, one quotient bit per cycle, for (num << 16) / den with num < den
module sfvs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sfvs_pkg::LEN_W-1:0]        num,
    input  logic [sfvs_pkg::LEN_W-1:0]        den,
    output logic [sfvs_pkg::GAIN_FRAC-1:0]    quo,
    output logic                              done
);
    import sfvs_pkg::*;

    localparam int CNT_W = $clog2(GAIN_FRAC + 1);

    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [GAIN_FRAC-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [LEN_W:0]       trial;
    logic [LEN_W+1:0]     diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, 1'b0};
        diff  = {1'b0, trial} - {2'b00, den};
        fits  = !diff[LEN_W+1];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            quo_next  = '0;
            cnt_next  = CNT_W'(GAIN_FRAC);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            quo_next = {quo_reg[GAIN_FRAC-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/sfvs_mul.sv */
// shift-add multiplier, one multiplier bit per cycle, lsb first, full product
module sfvs_mul #(
    parameter int WA       = 17,
    parameter int WB       = 17,
    parameter bit A_SIGNED = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WA-1:0]      a,
    input  logic [WB-1:0]      b,
    output logic [WA+WB-1:0]   prod,
    output logic               done
);
    localparam int CNT_W = $clog2(WB + 1);

    logic [WA-1:0]    a_reg, a_next;
    logic [WA-1:0]    acc_reg, acc_next;
    logic [WB-1:0]    sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic             acc_ext;
    logic             a_ext;
    logic [WA:0]      sum;

    // the multiplier register fills with the low product bits as it drains
    always_comb
    begin
        acc_ext = A_SIGNED & acc_reg[WA-1];
        a_ext   = A_SIGNED & a_reg[WA-1];
        sum     = {acc_ext, acc_reg} + (sh_reg[0] ? {a_ext, a_reg} : {(WA+1){1'b0}});
    end

    always_comb
    begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            acc_next  = '0;
            sh_next   = b;
            cnt_next  = CNT_W'(WB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[WA:1];
            sh_next  = {sum[0], sh_reg[WB-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
    end

    assign prod = {acc_reg, sh_reg};
    assign done = done_reg;

endmodule

/* hw/rtl/stereo_fade_volume_scaler_core.sv */
// top level: sample position tracking, fade sequencer and output register
//
// Stereo volume scaler with a quadratic fade-out. One beat on the s_axis side
// carries a left/right sample pair and a begin_fade flag in tuser; one beat on
// the m_axis side carries the scaled, saturated 16-bit pair and fade_done.
// The first sample past the end of the first fade after reset is consumed
// with no output beat. Registers are written through cfg_we/cfg_index/cfg_data;
// index 0 master_volume (15.16), index 1 fade_length (samples). The user must
// write them only while idle; the block itself does not enforce it. The serial
// units run one bit per cycle: a 16-step divider for the elapsed fraction, a
// 17-step square, a 31-step gain multiply and a 31-step multiply per channel
// (both channels side by side). One sample is in work at a time; the input is
// taken again as soon as the result sits in the output register, so a stalled
// receiver holds at most one finished beat plus one sample in work. Reset
// clears the position to zero, drops any fade and restores master_volume 1.0
// and fade_length 176400.
module stereo_fade_volume_scaler_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*sfvs_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // in_left, in_right
    input  logic                                s_axis_tuser,  // begin_fade
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*sfvs_pkg::OUT_W-1:0]        m_axis_tdata,  // out_left, out_right
    output logic                                m_axis_tuser,  // fade_done
    input  logic                                cfg_we,
    input  logic [sfvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfvs_pkg::CFG_W-1:0]          cfg_data
);
    import sfvs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_GAIN  = 3'd4;
    localparam logic [2:0] S_START = 3'd5;
    localparam logic [2:0] S_CHAN  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam int CH_PROD_W   = SAMPLE_W + VOL_W;
    localparam int GAIN_PROD_W = SQ_W + VOL_W;

    logic [2:0]           state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     origin_reg, origin_next;
    logic                 end_reg, end_next;
    logic [VOL_W-1:0]     mv_reg, mv_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     e_reg, e_next;
    logic                 infade_reg, infade_next;
    logic [VOL_W-1:0]     gain_reg, gain_next;
    logic [SAMPLE_W-1:0]  left_reg, left_next;
    logic [SAMPLE_W-1:0]  right_reg, right_next;
    logic                 ovalid_reg, ovalid_next;
    logic [2*OUT_W-1:0]   odata_reg, odata_next;
    logic                 ouser_reg, ouser_next;

    logic                 accept;
    logic [POS_W:0]       pos_diff;
    logic                 ended;
    logic                 out_free;

    logic                 div_start, div_done;
    logic [GAIN_FRAC-1:0] quo;
    logic [FADE_W-1:0]    fade;
    logic                 sq_start, sq_done;
    logic [2*FADE_W-1:0]  sq_prod;
    logic                 gmul_start, gmul_done;
    logic [GAIN_PROD_W-1:0] gmul_prod;
    logic                 chan_start, done_l, done_r;
    logic [CH_PROD_W-1:0] prod_l, prod_r;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign origin_next   = (accept && s_axis_tuser) ? pos_reg : origin_reg;
    assign pos_diff      = {1'b0, pos_reg} - {1'b0, origin_next};
    assign ended         = (e_reg >= len_reg);
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign fade          = FULL_GAIN - {1'b0, quo};

    assign div_start  = (state_reg == S_CHECK) && infade_reg && !ended;
    assign sq_start   = (state_reg == S_DIV) && div_done;
    assign gmul_start = (state_reg == S_SQ) && sq_done;
    assign chan_start = (state_reg == S_START);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        mv_next     = mv_reg;
        len_next    = len_reg;
        e_next      = e_reg;
        infade_next = infade_reg;
        gain_next   = gain_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MASTER_VOLUME: mv_next  = cfg_data[VOL_W-1:0];
                CFG_FADE_LENGTH:   len_next = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end

        if (m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = pos_reg + POS_W'(1);
                    e_next      = pos_diff[POS_W-1:0];
                    infade_next = !pos_diff[POS_W];
                    left_next   = s_axis_tdata[SAMPLE_W-1:0];
                    right_next  = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!infade_reg)
                begin
                    gain_next  = mv_reg;
                    state_next = S_START;
                end
                else if (ended)
                begin
                    // first sample past the end is swallowed
                    if (!end_reg)
                    begin
                        end_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        gain_next  = '0;
                        state_next = S_START;
                    end
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                if (sq_done)
                    state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (gmul_done)
                begin
                    // (f*f*mv) >> 32
                    gain_next  = gmul_prod[2*LEN_W+VOL_W-LEN_W-1:LEN_W];
                    state_next = S_START;
                end
            end
            S_START:
                state_next = S_CHAN;
            S_CHAN:
            begin
                if (done_l && done_r)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {sat16(prod_r[PROD_HI:PROD_LO]),
                                   sat16(prod_l[PROD_HI:PROD_LO])};
                    ouser_next  = end_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            origin_reg <= '1;
            end_reg    <= 1'b0;
            mv_reg     <= MASTER_VOLUME_RST;
            len_reg    <= FADE_LENGTH_RST;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            origin_reg <= origin_next;
            end_reg    <= end_next;
            mv_reg     <= mv_next;
            len_reg    <= len_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        infade_reg <= infade_next;
        gain_reg   <= gain_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        odata_reg  <= odata_next;
        ouser_reg  <= ouser_next;
    end

    sfvs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (e_reg),
        .den   (len_reg),
        .quo   (quo),
        .done  (div_done)
    );

    sfvs_mul #(.WA(FADE_W), .WB(FADE_W), .A_SIGNED(1'b0)) u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .a     (fade),
        .b     (fade),
        .prod  (sq_prod),
        .done  (sq_done)
    );

    sfvs_mul #(.WA(SQ_W), .WB(VOL_W), .A_SIGNED(1'b0)) u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gmul_start),
        .a     (sq_prod[SQ_W-1:0]),
        .b     (mv_reg),
        .prod  (gmul_prod),
        .done  (gmul_done)
    );

    sfvs_mul #(.WA(SAMPLE_W), .WB(VOL_W), .A_SIGNED(1'b1)) u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (chan_start),
        .a     (left_reg),
        .b     (gain_reg),
        .prod  (prod_l),
        .done  (done_l)
    );

    sfvs_mul #(.WA(SAMPLE_W), .WB(VOL_W), .A_SIGNED(1'b1)) u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (chan_start),
        .a     (right_reg),
        .b     (gain_reg),
        .prod  (prod_r),
        .done  (done_r)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg |=> end_reg)
        else $error("fade end flag cleared");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("sample position did not advance on accepted beat");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !$past(ovalid_reg)) |-> $past(state_reg) == S_OUT)
        else $error("output beat raised outside output state");

endmodule

/* tb/pcm_fade_checker.sv */
// checker for the fade volume scaler: predicts each output beat and compares it
module pcm_fade_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [2*sfvs_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // in_left, in_right
    input  logic                                s_axis_tuser,  // begin_fade
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [2*sfvs_pkg::OUT_W-1:0]        m_axis_tdata,  // out_left, out_right
    input  logic                                m_axis_tuser,  // fade_done
    input  logic                                cfg_we,
    input  logic [sfvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfvs_pkg::CFG_W-1:0]          cfg_data,
    output int                                  mismatches,
    output int                                  pending
);
    import sfvs_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] right;
        logic             done;
    } pcm_beat_t;

    pcm_beat_t          expected_pcm[$];
    logic [POS_W-1:0]   sample_ctr;
    logic [POS_W-1:0]   fade_start;
    logic               fade_over;
    logic [VOL_W-1:0]   volume_q16;
    logic [LEN_W-1:0]   fade_len;

    // (1 - elapsed/len)^2 * volume, all in 15.16
    function automatic logic [VOL_W-1:0] fade_gain(input logic [LEN_W-1:0] elapsed,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [VOL_W-1:0] vol);
        logic [63:0] frac;
        logic [63:0] remain;
        logic [63:0] sq;
        logic [63:0] prod;
        frac   = {elapsed, 16'h0000} / {32'h0, len};
        remain = 64'(FULL_GAIN) - frac;
        sq     = remain * remain;
        prod   = sq * 64'(vol);
        return prod[VOL_W+31:32];
    endfunction

    function automatic logic [OUT_W-1:0] scale_to_pcm16(input logic [SAMPLE_W-1:0] smp,
                                                        input logic [VOL_W-1:0] gain);
        logic signed [63:0] wide;
        logic signed [63:0] prod;
        logic signed [23:0] coarse;
        logic [OUT_W-1:0]   pcm;
        wide   = $signed(smp);
        prod   = wide * $signed({33'd0, gain});
        // shift by 16, keep 32 bits, shift by 8
        coarse = prod[47:24];
        if (coarse > 24'sd32767)
            pcm = OUT_MAX;
        else if (coarse < -24'sd32768)
            pcm = OUT_MIN;
        else
            pcm = coarse[OUT_W-1:0];
        return pcm;
    endfunction

    task automatic predict_sample(input logic [2*SAMPLE_W-1:0] pair, input logic start);
        logic [POS_W-1:0] here;
        logic [LEN_W-1:0] elapsed;
        logic [VOL_W-1:0] gain;
        pcm_beat_t        beat;
        here = sample_ctr;
        gain = volume_q16;
        if (start)
            fade_start = here;
        sample_ctr = here + 1'b1;
        if (here >= fade_start)
        begin
            elapsed = here - fade_start;
            if (elapsed >= fade_len)
            begin
                if (!fade_over)
                begin
                    // first sample past the fade is swallowed
                    fade_over = 1'b1;
                    return;
                end
                gain = '0;
            end
            else
                gain = fade_gain(elapsed, fade_len, volume_q16);
        end
        beat.left  = scale_to_pcm16(pair[SAMPLE_W-1:0], gain);
        beat.right = scale_to_pcm16(pair[2*SAMPLE_W-1:SAMPLE_W], gain);
        beat.done  = fade_over;
        expected_pcm.push_back(beat);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pcm_beat_t got;
        pcm_beat_t want;
        int        bad;
        if (!rst_n)
        begin
            sample_ctr = '0;
            fade_start = '1;
            fade_over  = 1'b0;
            volume_q16 = MASTER_VOLUME_RST;
            fade_len   = FADE_LENGTH_RST;
            expected_pcm.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.left  = m_axis_tdata[OUT_W-1:0];
                got.right = m_axis_tdata[2*OUT_W-1:OUT_W];
                got.done  = m_axis_tuser;
                if (expected_pcm.size() == 0)
                begin
                    $error("output beat with nothing expected: out_left %0d out_right %0d",
                           $signed(got.left), $signed(got.right));
                    bad++;
                end
                else
                begin
                    want = expected_pcm.pop_front();
                    if (got.left !== want.left)
                    begin
                        $error("out_left mismatch: expected %0d, actual %0d",
                               $signed(want.left), $signed(got.left));
                        bad++;
                    end
                    if (got.right !== want.right)
                    begin
                        $error("out_right mismatch: expected %0d, actual %0d",
                               $signed(want.right), $signed(got.right));
                        bad++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("fade_done mismatch: expected %0d, actual %0d",
                               want.done, got.done);
                        bad++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASTER_VOLUME: volume_q16 = cfg_data[VOL_W-1:0];
                    CFG_FADE_LENGTH:   fade_len   = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_sample(s_axis_tdata, s_axis_tuser);
            mismatches <= mismatches + bad;
            pending    <= expected_pcm.size();
        end
    end

endmodule

/* tb/tb_stereo_fade_volume_scaler_core.sv */
// testbench top: sample and register stimulus for the fade volume scaler, and the verdict
module tb_stereo_fade_volume_scaler_core;
    import sfvs_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [2*SAMPLE_W-1:0]   s_axis_tdata;   // in_left, in_right
    logic                    s_axis_tuser;   // begin_fade
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [2*OUT_W-1:0]      m_axis_tdata;   // out_left, out_right
    logic                    m_axis_tuser;   // fade_done
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    int                      mismatches;
    int                      pending;
    bit                      tx_gaps = 1'b0;
    bit                      rx_gaps = 1'b0;
    int                      rx_hold = 0;
    logic [LEN_W-1:0]        fade_len_now = FADE_LENGTH_RST;
    // elapsed count the next sample would see, -1 while no fade runs
    longint                  fade_age = -1;

    stereo_fade_volume_scaler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pcm_fade_checker pcm_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #6 clk = ~clk;

    initial
    begin
        #36000000;
        $display("== FAIL ==");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold != 0)
            begin
                stall = rx_hold;
                rx_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                v = $urandom;
                v = {{8{v[23]}}, v[23:0]};
            end
            6, 7:
                v = $urandom;
            8:
                case ($urandom_range(0, 5))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h007F_FFFF;
                    3:       v = 32'hFF80_0000;
                    4:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            default:
                v = $urandom_range(0, 600) - 300;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_volume();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = CFG_W'(MASTER_VOLUME_RST);
            1:       v = $urandom_range(0, 32'h2_0000);
            2:       v = $urandom_range(32'h2_0000, 32'h100_0000);
            3:       v = $urandom;
            default: v = $urandom_range(0, 32'h8000);
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] left,
                               input logic [SAMPLE_W-1:0] right,
                               input logic start);
        @(negedge clk);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            if (s_axis_tvalid)
                s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tdata  <= {right, left};
        s_axis_tuser  <= start;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (start)
            fade_age = 1;
        else if (fade_age >= 0)
            fade_age++;
    endtask

    // stop sending and let every expected beat and any swallowed sample go through
    task automatic settle_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FADE_LENGTH)
            fade_len_now = value;
    endtask

    // keep_fading restarts the fade before it can run out
    task automatic random_phase(input int count, input bit keep_fading, input int hold_at);
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                start;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                rx_hold = 400;
            left  = pick_sample();
            right = pick_sample();
            start = ($urandom_range(0, keep_fading ? 24 : 14) == 0);
            if (keep_fading && fade_age >= 0 && fade_age >= longint'(fade_len_now))
                start = 1'b1;
            send_sample(left, right, start);
        end
        settle_block();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MASTER_VOLUME;
        cfg_data      = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset gains, full-scale and tiny samples, then a long fade starting
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_sample(32'h007F_FFFF, 32'hFF80_0000, 1'b0);
        send_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0100, 32'hFFFF_FF00, 1'b0);
        send_sample(32'h007F_FFFF, 32'hFF80_0000, 1'b1);
        send_sample(32'h0040_0000, 32'hFFC0_0000, 1'b0);
        settle_block();

        // largest gain and longest fade: saturation and product truncation
        write_reg(CFG_MASTER_VOLUME, 32'h7FFF_FFFF);
        write_reg(CFG_FADE_LENGTH, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_sample(32'h0000_0080, 32'hFFFF_FF80, 1'b0);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        settle_block();

        write_reg(CFG_MASTER_VOLUME, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        settle_block();

        // fades that never run out
        for (int ph = 0; ph < 6; ph++)
        begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            write_reg(CFG_MASTER_VOLUME, pick_volume());
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_FADE_LENGTH, $urandom_range(1, 8));
                1:       write_reg(CFG_FADE_LENGTH, $urandom_range(9, 300));
                default: write_reg(CFG_FADE_LENGTH, $urandom_range(300, 5000));
            endcase
            random_phase(75, 1'b1, ph == 1 ? 20 : -1);
        end

        // zero length ends the fade at once and swallows that sample
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        write_reg(CFG_MASTER_VOLUME, CFG_W'(MASTER_VOLUME_RST));
        write_reg(CFG_FADE_LENGTH, 32'h0);
        send_sample(32'h0012_3456, 32'hFFED_CBAA, 1'b1);
        send_sample(32'h0012_3456, 32'hFFED_CBAA, 1'b0);
        settle_block();

        // a new fade after the end runs out with no swallowed sample
        write_reg(CFG_FADE_LENGTH, 32'd3);
        send_sample(32'h0012_3456, 32'hFFED_CBAA, 1'b1);
        for (int i = 0; i < 4; i++)
            send_sample(32'h0012_3456, 32'hFFED_CBAA, 1'b0);
        settle_block();

        // after the end: silence and restarted fades
        for (int ph = 0; ph < 6; ph++)
        begin
            tx_gaps = (ph != 5) && ($urandom_range(0, 3) != 0);
            rx_gaps = (ph != 5) && ($urandom_range(0, 3) != 0);
            write_reg(CFG_MASTER_VOLUME, pick_volume());
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_FADE_LENGTH, 32'h0);
                1:       write_reg(CFG_FADE_LENGTH, 32'h1);
                2:       write_reg(CFG_FADE_LENGTH, $urandom_range(2, 20));
                default: write_reg(CFG_FADE_LENGTH, $urandom_range(20, 400));
            endcase
            random_phase(75, 1'b0, -1);
        end

        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
